### src/vcle_pkg.sv
package vcle_pkg;

   // field and register widths
   localparam int PIX_W      = 8;
   localparam int WREG_W     = 11;
   localparam int HREG_W     = 13;
   localparam int ROW_W      = 12;
   localparam int OCOL_W     = 10;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   // line buffer slots
   localparam int NUM_SLOTS = 6;
   localparam int SLOT_W    = 3;

   // arithmetic widths
   localparam int SUM_W      = 10;  // sum of three pixels, also |above - below|
   localparam int D2_W       = 20;
   localparam int D3_W       = 30;
   localparam int D6_W       = 60;
   localparam int POW_W      = 12;  // floor(d^1.2) <= 2890
   localparam int POW_BIT_W  = 4;
   localparam int SQ_W       = 24;
   localparam int P4_W       = 48;
   localparam int P5_W       = 60;
   localparam int PROD_W     = 20;  // a * centre
   localparam int ROOT_W     = 8;
   localparam int ROOT_BIT_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [HREG_W-1:0] HEIGHT_MIN   = 13'd8;
   localparam logic [HREG_W-1:0] HEIGHT_MAX   = 13'd4096;

   localparam logic [ROW_W-1:0] FIRST_OUT_ROW = 12'd7;
   localparam logic [ROW_W-1:0] ROW_LAG       = 12'd3;

   localparam logic [ROOT_W-1:0] ROOT_CLAMP   = 8'd255;
   localparam logic [ROOT_W-1:0] ROOT_FLOOR   = 8'd80;
   localparam logic [ROOT_W-1:0] ROOT_LOW_OUT = 8'd1;

   localparam logic [POW_BIT_W-1:0]  POW_TOP_BIT  = 4'd11;
   localparam logic [ROOT_BIT_W-1:0] ROOT_TOP_BIT = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_D2,
      ST_D3,
      ST_D6,
      ST_SQ,
      ST_P4,
      ST_P5,
      ST_CMP,
      ST_MULB,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic sq_d;
      logic cube_d;
      logic six_d;
      logic pow_sq;
      logic pow_p4;
      logic pow_p5;
      logic pow_cmp;
      logic mul_b;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic pow_last;
      logic root_last;
      logic out_busy;
   } sts_type;

   // (slot + k) mod 6, both operands below 6
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                  input logic [SLOT_W-1:0] k);
      logic [SLOT_W:0] sum;
      sum = {1'b0, slot} + {1'b0, k};
      if (sum >= (SLOT_W+1)'(NUM_SLOTS)) begin
         sum = sum - (SLOT_W+1)'(NUM_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

### src/vcle_ram.sv
module vcle_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/vcle_ctrl.sv
module vcle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  vcle_pkg::sts_type sts,
   output vcle_pkg::cmd_type cmd
);

   vcle_pkg::state_type state_ff;
   vcle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vcle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         vcle_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = vcle_pkg::ST_LOAD;
            end
         end
         vcle_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = sts.emit ? vcle_pkg::ST_D2 : vcle_pkg::ST_IDLE;
         end
         vcle_pkg::ST_D2: begin
            cmd.sq_d = 1'b1;
            state_in = vcle_pkg::ST_D3;
         end
         vcle_pkg::ST_D3: begin
            cmd.cube_d = 1'b1;
            state_in   = vcle_pkg::ST_D6;
         end
         vcle_pkg::ST_D6: begin
            cmd.six_d = 1'b1;
            state_in  = vcle_pkg::ST_SQ;
         end
         vcle_pkg::ST_SQ: begin
            cmd.pow_sq = 1'b1;
            state_in   = vcle_pkg::ST_P4;
         end
         vcle_pkg::ST_P4: begin
            cmd.pow_p4 = 1'b1;
            state_in   = vcle_pkg::ST_P5;
         end
         vcle_pkg::ST_P5: begin
            cmd.pow_p5 = 1'b1;
            state_in   = vcle_pkg::ST_CMP;
         end
         vcle_pkg::ST_CMP: begin
            cmd.pow_cmp = 1'b1;
            state_in    = sts.pow_last ? vcle_pkg::ST_MULB : vcle_pkg::ST_SQ;
         end
         vcle_pkg::ST_MULB: begin
            cmd.mul_b = 1'b1;
            state_in  = vcle_pkg::ST_ROOT;
         end
         vcle_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            state_in      = sts.root_last ? vcle_pkg::ST_DONE : vcle_pkg::ST_ROOT;
         end
         vcle_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = vcle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vcle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/vcle_dp.sv
module vcle_dp #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vcle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vcle_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [vcle_pkg::PIX_W-1:0]          req_tdata,
   input  vcle_pkg::cmd_type                   cmd,
   output vcle_pkg::sts_type                   sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vcle_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PIX_W = vcle_pkg::PIX_W;
   localparam int HREG_W = vcle_pkg::HREG_W;
   localparam int ROW_W = vcle_pkg::ROW_W;
   localparam int SLOT_W = vcle_pkg::SLOT_W;
   localparam int NUM_SLOTS = vcle_pkg::NUM_SLOTS;
   localparam int SUM_W = vcle_pkg::SUM_W;
   localparam int POW_W = vcle_pkg::POW_W;
   localparam int ROOT_W = vcle_pkg::ROOT_W;
   localparam int PROD_W = vcle_pkg::PROD_W;
   localparam int RSQ_W = 2 * vcle_pkg::ROOT_W;
   localparam int PAD_W = vcle_pkg::RSP_DATA_W - PIX_W - vcle_pkg::OCOL_W - ROW_W;
   localparam logic [HREG_W-1:0] MAXW = HREG_W'(MAX_WIDTH);

   // control state
   logic [vcle_pkg::WREG_W-1:0] width_ff, width_in;
   logic [HREG_W-1:0]           height_ff, height_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // item being worked on
   logic [PIX_W-1:0]  item_pix_ff, item_pix_in;
   logic [CW-1:0]     item_col_ff, item_col_in;
   logic [ROW_W-1:0]  item_row_ff, item_row_in;
   logic [SLOT_W-1:0] item_slot_ff, item_slot_in;
   logic              item_emit_ff, item_emit_in;
   logic              item_end_ff, item_end_in;

   // arithmetic
   logic [PIX_W-1:0]              center_ff, center_in;
   logic [SUM_W-1:0]              d_ff, d_in;
   logic [vcle_pkg::D2_W-1:0]     d2_ff, d2_in;
   logic [vcle_pkg::D3_W-1:0]     d3_ff, d3_in;
   logic [vcle_pkg::D6_W-1:0]     d6_ff, d6_in;
   logic [POW_W-1:0]              pow_t_ff, pow_t_in;
   logic [vcle_pkg::POW_BIT_W-1:0] pow_bit_ff, pow_bit_in;
   logic [vcle_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [vcle_pkg::P4_W-1:0]     p4_ff, p4_in;
   logic [vcle_pkg::P5_W-1:0]     p5_ff, p5_in;
   logic [PROD_W-1:0]             b_ff, b_in;
   logic [ROOT_W-1:0]             root_ff, root_in;
   logic [vcle_pkg::ROOT_BIT_W-1:0] root_bit_ff, root_bit_in;

   // result register
   logic [PIX_W-1:0]             out_pix_ff, out_pix_in;
   logic [vcle_pkg::OCOL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]             out_row_ff, out_row_in;
   logic                         out_end_ff, out_end_in;

   logic [PIX_W-1:0]  q   [NUM_SLOTS];
   logic [PIX_W-1:0]  rot [NUM_SLOTS];
   logic [HREG_W-1:0] w_eff, h_eff;
   logic              last_col, last_row;
   logic [SUM_W-1:0]  above, below;
   logic [POW_W-1:0]  pow_cand;
   logic [ROOT_W-1:0] root_cand;
   logic [RSQ_W-1:0]  root_sq;
   logic [ROOT_W-1:0] result;

   // six line buffers, one per row slot
   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_line
      vcle_ram #(
         .DATA_W(PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock  (clock),
         .wr_en  (cmd.load && (item_slot_ff == SLOT_W'(k))),
         .wr_addr(item_col_ff),
         .wr_data(item_pix_ff),
         .rd_en  (cmd.accept),
         .rd_addr(col_ff),
         .rd_data(q[k])
      );
   end

   // rot[k] holds row (R-6+k), which lives in slot (R+k) mod 6
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         rot[k] = '0;
         for (int j = 0; j < NUM_SLOTS; j++) begin
            if (vcle_pkg::slot_add(item_slot_ff, SLOT_W'(k)) == SLOT_W'(j)) begin
               rot[k] = q[j];
            end
         end
      end
   end

   always_comb begin
      w_eff = HREG_W'(width_ff);
      if (w_eff == '0) begin
         w_eff = HREG_W'(1);
      end else if (w_eff > MAXW) begin
         w_eff = MAXW;
      end
      h_eff = height_ff;
      if (h_eff < vcle_pkg::HEIGHT_MIN) begin
         h_eff = vcle_pkg::HEIGHT_MIN;
      end else if (h_eff > vcle_pkg::HEIGHT_MAX) begin
         h_eff = vcle_pkg::HEIGHT_MAX;
      end
   end

   assign last_col = HREG_W'(col_ff) >= (w_eff - HREG_W'(1));
   assign last_row = HREG_W'(row_ff) >= (h_eff - HREG_W'(1));

   assign above = SUM_W'(rot[0]) + SUM_W'(rot[1]) + SUM_W'(rot[2]);
   assign below = SUM_W'(rot[4]) + SUM_W'(rot[5]) + SUM_W'(item_pix_ff);

   assign pow_cand  = pow_t_ff | (POW_W'(1) << pow_bit_ff);
   assign root_cand = root_ff | (ROOT_W'(1) << root_bit_ff);
   assign root_sq   = RSQ_W'(root_cand) * RSQ_W'(root_cand);

   always_comb begin
      if (b_ff[PROD_W-1:RSQ_W] != '0) begin
         result = vcle_pkg::ROOT_CLAMP;
      end else if (root_ff < vcle_pkg::ROOT_FLOOR) begin
         result = vcle_pkg::ROOT_LOW_OUT;
      end else begin
         result = root_ff;
      end
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      item_pix_in  = item_pix_ff;
      item_col_in  = item_col_ff;
      item_row_in  = item_row_ff;
      item_slot_in = item_slot_ff;
      item_emit_in = item_emit_ff;
      item_end_in  = item_end_ff;
      center_in    = center_ff;
      d_in         = d_ff;
      d2_in        = d2_ff;
      d3_in        = d3_ff;
      d6_in        = d6_ff;
      pow_t_in     = pow_t_ff;
      pow_bit_in   = pow_bit_ff;
      sq_in        = sq_ff;
      p4_in        = p4_ff;
      p5_in        = p5_ff;
      b_in         = b_ff;
      root_in      = root_ff;
      root_bit_in  = root_bit_ff;
      out_pix_in   = out_pix_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_end_in   = out_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_wr_en) begin
         case (csr_index)
            vcle_pkg::CSR_IMAGE_WIDTH: width_in = csr_wdata[vcle_pkg::WREG_W-1:0];
            vcle_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata[HREG_W-1:0];
            default: ;
         endcase
      end

      if (cmd.accept) begin
         item_pix_in  = req_tdata;
         item_col_in  = col_ff;
         item_row_in  = row_ff;
         item_slot_in = slot_ff;
         item_emit_in = row_ff >= vcle_pkg::FIRST_OUT_ROW;
         item_end_in  = last_col && last_row;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = vcle_pkg::slot_add(slot_ff, SLOT_W'(1));
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      if (cmd.load) begin
         center_in = rot[3];
         d_in      = (above > below) ? (above - below) : (below - above);
      end
      if (cmd.sq_d) begin
         d2_in = vcle_pkg::D2_W'(d_ff) * vcle_pkg::D2_W'(d_ff);
      end
      if (cmd.cube_d) begin
         d3_in = vcle_pkg::D3_W'(d2_ff) * vcle_pkg::D3_W'(d_ff);
      end
      if (cmd.six_d) begin
         d6_in      = vcle_pkg::D6_W'(d3_ff) * vcle_pkg::D6_W'(d3_ff);
         pow_t_in   = '0;
         pow_bit_in = vcle_pkg::POW_TOP_BIT;
      end
      if (cmd.pow_sq) begin
         sq_in = vcle_pkg::SQ_W'(pow_cand) * vcle_pkg::SQ_W'(pow_cand);
      end
      if (cmd.pow_p4) begin
         p4_in = vcle_pkg::P4_W'(sq_ff) * vcle_pkg::P4_W'(sq_ff);
      end
      if (cmd.pow_p5) begin
         p5_in = vcle_pkg::P5_W'(p4_ff) * vcle_pkg::P5_W'(pow_cand);
      end
      if (cmd.pow_cmp) begin
         // keep the bit when cand^5 <= d^6
         if (p5_ff <= d6_ff) begin
            pow_t_in = pow_cand;
         end
         pow_bit_in = pow_bit_ff - vcle_pkg::POW_BIT_W'(1);
      end
      if (cmd.mul_b) begin
         b_in        = PROD_W'(pow_t_ff) * PROD_W'(center_ff);
         root_in     = '0;
         root_bit_in = vcle_pkg::ROOT_TOP_BIT;
      end
      if (cmd.root_step) begin
         if (root_sq <= b_ff[RSQ_W-1:0]) begin
            root_in = root_cand;
         end
         root_bit_in = root_bit_ff - vcle_pkg::ROOT_BIT_W'(1);
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         out_pix_in   = result;
         out_col_in   = vcle_pkg::OCOL_W'(item_col_ff);
         out_row_in   = item_row_ff - vcle_pkg::ROW_LAG;
         out_end_in   = item_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= vcle_pkg::WIDTH_RESET;
         height_ff    <= vcle_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_pix_ff  <= item_pix_in;
      item_col_ff  <= item_col_in;
      item_row_ff  <= item_row_in;
      item_slot_ff <= item_slot_in;
      item_emit_ff <= item_emit_in;
      item_end_ff  <= item_end_in;
      center_ff    <= center_in;
      d_ff         <= d_in;
      d2_ff        <= d2_in;
      d3_ff        <= d3_in;
      d6_ff        <= d6_in;
      pow_t_ff     <= pow_t_in;
      pow_bit_ff   <= pow_bit_in;
      sq_ff        <= sq_in;
      p4_ff        <= p4_in;
      p5_ff        <= p5_in;
      b_ff         <= b_in;
      root_ff      <= root_in;
      root_bit_ff  <= root_bit_in;
      out_pix_ff   <= out_pix_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_end_ff   <= out_end_in;
   end

   assign sts.emit      = item_emit_ff;
   assign sts.pow_last  = pow_bit_ff == '0;
   assign sts.root_last = root_bit_ff == '0;
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), out_row_ff, out_col_ff, out_pix_ff};
   assign rsp_tlast  = out_end_ff;

endmodule

### src/vertical_contrast_line_extract.sv
// Vertical contrast line extractor. Gray pixels enter in raster order, one per
// req beat, and six line buffers (block RAMs of MAX_WIDTH bytes, one per row slot,
// not cleared after reset) keep the six previous rows. From input row 7 on,
// every pixel closes the window of the pixel three rows up in its column:
// d = |sum of the three above - sum of the three below|, a = floor(d^1.2),
// result = floor(sqrt(a * centre)), clamped to 255 and forced to 1 below 80.
// One rsp beat leaves per pixel of rows 7 and up, tagged with column and row
// (input row - 3); tlast marks the last pixel of the frame. Rows 0..6 give no
// beat. A pixel of rows 0..6 needs a line buffer read, then write-back; a
// pixel that produces a result then also runs the exponent search (12 result bits,
// each through one multiply chain to t^5, compared against d^6) and a
// bit-serial square root. Only one pixel is worked on at a time.
// The result register lets the next pixel be taken while a beat waits on rsp.
// image_width and image_height must be written through the csr port only while
// the block is idle; the block itself does not enforce this.
module vertical_contrast_line_extract #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes: index 0 image_width, index 1 image_height
   input  logic                            csr_wr_en,
   input  logic [vcle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vcle_pkg::CSR_DATA_W-1:0] csr_wdata,
   // pixel stream in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vcle_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   // result stream out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vcle_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] pixel_out,
                                                        // [17:8] out_column,
                                                        // [29:18] out_row
   output logic                            rsp_tlast    // frame_end
);

   vcle_pkg::cmd_type cmd;
   vcle_pkg::sts_type sts;

   // sequencer: one pixel at a time through the shared arithmetic
   vcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, line buffers, arithmetic and result register
   vcle_dp #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // an accepted beat is written back to the line buffers in the next cycle
   a_accept_then_load : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.load)
      else $error("accepted pixel not followed by line buffer write");

   // a finished result never overwrites a beat still waiting on rsp
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while full");

   // the sequencer issues at most one command per cycle
   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   // border-row pixels return straight to ready
   a_border_quick : assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !sts.emit) |=> req_tready)
      else $error("pixel without result did not free the input");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int MAX_WIDTH    = 1024;
   localparam int IDLE_PCT     = 11;    // chance per cycle that a side holds off
   localparam int DRAIN_CYCLES = 80;    // long enough for a result pixel to finish in the block
   localparam int STALL_LIMIT  = 4000;  // cycles without any beat or csr write

   // one expected rsp beat
   typedef struct packed {
      logic [vcle_pkg::ROOT_W-1:0] strength;
      logic [vcle_pkg::OCOL_W-1:0] line_col;
      logic [vcle_pkg::ROW_W-1:0]  line_row;
      logic                        frame_end;
   } line_beat_type;

   // pixel content styles for the random frames
   typedef enum int {TEX_NOISE, TEX_FLAT, TEX_BANDS, TEX_RAMP} texture_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_wr_en  = 1'b0;
   logic [vcle_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [vcle_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vcle_pkg::PIX_W-1:0]      req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vcle_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   // predictor copy of the block's registers, counters and line buffers
   logic [vcle_pkg::WREG_W-1:0] width_reg  = vcle_pkg::WIDTH_RESET;
   logic [vcle_pkg::HREG_W-1:0] height_reg = vcle_pkg::HEIGHT_RESET;
   int unsigned                 col_cnt    = 0;
   int unsigned                 row_cnt    = 0;
   bit [vcle_pkg::PIX_W-1:0]    line_hist [vcle_pkg::NUM_SLOTS][MAX_WIDTH];

   line_beat_type expected_beats [$];
   int            pixels_sent = 0;
   int            error_count = 0;
   int            idle_cycles = 0;
   bit            steady_flow = 1'b0;   // no hold-off on either side while set

   // stimulus shaping for the random frames
   texture_type texture     = TEX_NOISE;
   int          flat_base   = 128;
   int          spread      = 4;
   int          ramp_step   = 0;
   int          band_level [64];

   vertical_contrast_line_extract #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver hold-off, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Line strength of one accepted pixel. Updates the counters and line buffers
   // exactly as the block does; returns 1 when the pixel closes a window.
   function automatic bit predict_strength(input logic [vcle_pkg::PIX_W-1:0] pix,
                                           output line_beat_type beat);
      int unsigned       w, h, c, r;
      int unsigned       above, below, diff, expo, prod, lo, hi, mid;
      longint unsigned   d6, m5;
      bit                row_done, frame_done, emits;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < vcle_pkg::HEIGHT_MIN) h = vcle_pkg::HEIGHT_MIN;
      if (h > vcle_pkg::HEIGHT_MAX) h = vcle_pkg::HEIGHT_MAX;
      c = col_cnt;
      r = row_cnt;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      row_done   = (c >= w - 1);
      frame_done = (r >= h - 1);
      emits      = (r >= vcle_pkg::FIRST_OUT_ROW);
      beat       = '0;
      if (emits) begin
         // rows r-6..r-4 above the centre (row r-3), rows r-2, r-1 and r below
         above = line_hist[(r - 6) % vcle_pkg::NUM_SLOTS][c]
               + line_hist[(r - 5) % vcle_pkg::NUM_SLOTS][c]
               + line_hist[(r - 4) % vcle_pkg::NUM_SLOTS][c];
         below = line_hist[(r - 2) % vcle_pkg::NUM_SLOTS][c]
               + line_hist[(r - 1) % vcle_pkg::NUM_SLOTS][c] + pix;
         diff  = (above > below) ? above - below : below - above;
         // floor(d^1.2): largest t with t^5 <= d^6
         d6 = 1;
         repeat (6) d6 = d6 * diff;
         lo = 0;
         hi = 4095;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            m5  = mid;
            repeat (4) m5 = m5 * mid;
            if (m5 <= d6) lo = mid;
            else          hi = mid - 1;
         end
         expo = lo;
         prod = expo * line_hist[(r - 3) % vcle_pkg::NUM_SLOTS][c];
         lo = 0;
         hi = 2047;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= prod) lo = mid;
            else                   hi = mid - 1;
         end
         if (lo > vcle_pkg::ROOT_CLAMP)      lo = vcle_pkg::ROOT_CLAMP;
         else if (lo < vcle_pkg::ROOT_FLOOR) lo = vcle_pkg::ROOT_LOW_OUT;
         beat.strength  = lo[vcle_pkg::ROOT_W-1:0];
         beat.line_col  = c[vcle_pkg::OCOL_W-1:0];
         beat.line_row  = vcle_pkg::ROW_W'(r - vcle_pkg::ROW_LAG);
         beat.frame_end = row_done && frame_done;
      end
      line_hist[r % vcle_pkg::NUM_SLOTS][c] = pix;
      if (row_done) begin
         col_cnt = 0;
         row_cnt = frame_done ? 0 : ((r + 1) & 32'hFFF);
      end else begin
         col_cnt = c + 1;
      end
      return emits;
   endfunction

   // next pixel in the current texture, from the predictor's position
   function automatic logic [vcle_pkg::PIX_W-1:0] texture_pixel();
      int v;
      case (texture)
         TEX_FLAT:  v = flat_base + $urandom_range(0, 2 * spread) - spread;
         TEX_BANDS: v = band_level[row_cnt % 64] + $urandom_range(0, 2 * spread) - spread;
         TEX_RAMP:  v = flat_base + ramp_step * int'(row_cnt) + $urandom_range(0, spread);
         default:   v = $urandom_range(0, 255);
      endcase
      if (v < 0)   v = 0;
      if (v > 255) v = 255;
      return v[vcle_pkg::PIX_W-1:0];
   endfunction

   // One req beat. Called at a falling edge; returns at the falling edge after
   // the beat with tvalid still high, so a following call keeps the stream going.
   task automatic send_pixel(input logic [vcle_pkg::PIX_W-1:0] pix);
      line_beat_type beat;
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_strength(pix, beat)) expected_beats.push_back(beat);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_until(input int unsigned row, input int unsigned col);
      while (!(row_cnt == row && col_cnt == col)) send_pixel(texture_pixel());
   endtask

   // drop tvalid, let every pending beat out, then give the datapath time to settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [vcle_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vcle_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      if (idx == vcle_pkg::CSR_IMAGE_WIDTH) width_reg  = value[vcle_pkg::WREG_W-1:0];
      else                                  height_reg = value[vcle_pkg::HREG_W-1:0];
   endtask

   // Smallest frames: width 0 (runs as 1) with height 0 (runs as 8) and one
   // window at full contrast -> clamp. Then width 2: flat column (d = 0, below
   // threshold) beside a column with d = 100 that lands just below the clamp.
   task automatic test_corner_windows();
      logic [vcle_pkg::PIX_W-1:0] spike [8] = '{8'd0, 8'd255, 8'd255, 8'd255,
                                                8'd255, 8'd0, 8'd0, 8'd0};
      logic [vcle_pkg::PIX_W-1:0] step  [8] = '{8'd0, 8'd100, 8'd100, 8'd100,
                                                8'd255, 8'd67, 8'd67, 8'd66};
      wait_idle();
      write_reg(vcle_pkg::CSR_IMAGE_WIDTH, '0);
      write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, '0);
      for (int i = 0; i < 8; i++) send_pixel(spike[i]);
      wait_idle();
      write_reg(vcle_pkg::CSR_IMAGE_WIDTH, vcle_pkg::CSR_DATA_W'(2));
      write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, vcle_pkg::HEIGHT_MIN);
      for (int i = 0; i < 8; i++) begin
         send_pixel(8'd128);
         send_pixel(step[i]);
      end
   endtask

   // Registers changed in the middle of a frame, only ever shrinking the width:
   // a column count past the new width closes the row on the next pixel, and a
   // row count past the new height closes the frame at the end of that row.
   task automatic test_resize_midframe();
      wait_idle();
      texture = TEX_NOISE;
      write_reg(vcle_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);    // masked to 2047, runs as 1024
      write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, 13'h1FFF);   // runs as 4096
      send_until(0, 20);
      wait_idle();
      write_reg(vcle_pkg::CSR_IMAGE_WIDTH, vcle_pkg::CSR_DATA_W'(9));
      send_until(9, 6);
      wait_idle();
      write_reg(vcle_pkg::CSR_IMAGE_WIDTH, vcle_pkg::CSR_DATA_W'(3));
      write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, vcle_pkg::HEIGHT_MAX);
      send_until(11, 1);
      wait_idle();
      write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, vcle_pkg::CSR_DATA_W'(5));  // runs as 8
      send_until(0, 0);
   endtask

   // Whole small frames with random size and texture. Width is written with
   // junk in the bits above the register.
   task automatic test_textured_frames(input int pixel_budget, input bit full_rate);
      int stop_at, w, h;
      stop_at = pixels_sent + pixel_budget;
      while (pixels_sent < stop_at) begin
         wait_idle();
         steady_flow = full_rate;
         w = $urandom_range(1, 16);
         h = $urandom_range(8, 14);
         write_reg(vcle_pkg::CSR_IMAGE_WIDTH,
                   vcle_pkg::CSR_DATA_W'(w)
                   | vcle_pkg::CSR_DATA_W'($urandom_range(0, 3) << vcle_pkg::WREG_W));
         write_reg(vcle_pkg::CSR_IMAGE_HEIGHT, vcle_pkg::CSR_DATA_W'(h));
         texture   = texture_type'($urandom_range(0, 3));
         flat_base = $urandom_range(0, 255);
         spread    = $urandom_range(0, 30);
         ramp_step = $urandom_range(0, 24) - 12;
         foreach (band_level[i])
            band_level[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                          : ($urandom_range(0, 1) ? 255 : 0);
         repeat (w * h) send_pixel(texture_pixel());
      end
      steady_flow = 1'b0;
   endtask

   // rsp checker: every accepted beat against the oldest expectation
   always @(posedge clock) begin : check_beats
      line_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected rsp beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata[7:0] !== want.strength) begin
               $error("pixel_out: expected %0d, got %0d", want.strength, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[17:8] !== want.line_col) begin
               $error("out_column: expected %0d, got %0d", want.line_col, rsp_tdata[17:8]);
               error_count++;
            end
            if (rsp_tdata[29:18] !== want.line_row) begin
               $error("out_row: expected %0d, got %0d", want.line_row, rsp_tdata[29:18]);
               error_count++;
            end
            if (rsp_tdata[vcle_pkg::RSP_DATA_W-1:30] !== '0) begin
               $error("tdata pad: expected 0, got %0d",
                      rsp_tdata[vcle_pkg::RSP_DATA_W-1:30]);
               error_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any beat or register write
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_corner_windows();
      test_resize_midframe();
      test_textured_frames(760, 1'b0);
      test_textured_frames(200, 1'b1);   // long stretch at full rate
      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
src/vcle_pkg.sv
src/vcle_ram.sv
src/vcle_ctrl.sv
src/vcle_dp.sv
src/vertical_contrast_line_extract.sv
test/tb.sv
